// ----- hw/rtl/fat12cw_pkg.sv -----
// ----------------------------------------------------------------------------
// fat12cw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fat12cw_pkg;

    localparam int CLUSTER_W = 12;
    localparam int PAIR_W    = 11;
    localparam int BYTES_W   = 24;
    localparam int LEN_W     = 32;
    localparam int OFF_W     = 21;
    localparam int CNT_W     = 10;
    localparam int STATUS_W  = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WALK = 1'b1;

    localparam logic [CLUSTER_W-1:0] CL_FREE   = 12'h000;
    localparam logic [CLUSTER_W-1:0] CL_EOC_LO = 12'hFF0;
    localparam logic [CLUSTER_W-1:0] CL_BAD_HI = 12'hFF7;
    localparam logic [CLUSTER_W-1:0] CL_BASE   = 12'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_TRUNC     = 2'd2
    } t_status;

    typedef struct packed {
        logic we_even;
        logic we_odd;
    } t_tbl_wr;

endpackage

// ----- hw/rtl/fat12cw_if.sv -----
// ----------------------------------------------------------------------------
// fat12cw_if
// Valid/ready channels for walker input items and result items.
// ----------------------------------------------------------------------------
interface fat12cw_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [fat12cw_pkg::PAIR_W-1:0]      pair_index;
    logic [fat12cw_pkg::BYTES_W-1:0]     table_bytes;
    logic [fat12cw_pkg::CLUSTER_W-1:0]   start_cluster;
    logic [fat12cw_pkg::LEN_W-1:0]       file_length;

    modport source (output valid, operation, pair_index, table_bytes, start_cluster,
                    file_length, input ready);
    modport sink   (input valid, operation, pair_index, table_bytes, start_cluster,
                    file_length, output ready);
endinterface

interface fat12cw_out_if;
    logic                                valid;
    logic                                ready;
    logic [fat12cw_pkg::CLUSTER_W-1:0]   cluster;
    logic [fat12cw_pkg::OFF_W-1:0]       byte_offset;
    logic [fat12cw_pkg::CNT_W-1:0]       byte_count;
    logic                                last;
    logic [fat12cw_pkg::STATUS_W-1:0]    status;

    modport source (output valid, cluster, byte_offset, byte_count, last, status,
                    input ready);
    modport sink   (input valid, cluster, byte_offset, byte_count, last, status,
                    output ready);
endinterface

// ----- hw/rtl/fat12_cluster_chain_walker.sv -----
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Holds a FAT12 table and walks cluster chains, one result per cluster.
// ----------------------------------------------------------------------------
// A load item writes an entry pair into the even and odd table banks. A walk
// item is accepted, after which the block gives one result per cycle while
// the output is taken: the table read for the next cluster is issued in the
// same cycle the current result is registered. A walk keeps the input
// blocked until its last result is registered.
// A bad first cluster gives a single error result. The table has no reset;
// entries must be loaded before a walk reaches them.
module fat12_cluster_chain_walker #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int SECTOR_BYTES  = 512,
    parameter int MAX_RUN       = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fat12cw_in_if.sink           i_item,
    fat12cw_out_if.source        o_item
);

    localparam int EW         = $clog2(TABLE_ENTRIES);
    localparam int BANK_AW    = EW - 1;
    localparam int BANK_DEPTH = (TABLE_ENTRIES + 1) / 2;
    localparam int TW         = $clog2(SECTOR_BYTES + 1);
    localparam int RW         = $clog2(MAX_RUN + 1);
    localparam int CLW        = fat12cw_pkg::CLUSTER_W;
    localparam int OFFW       = fat12cw_pkg::OFF_W;
    localparam int LENW       = fat12cw_pkg::LEN_W;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [CLW-1:0]                  r_cl;
    logic [LENW-1:0]                 r_rem;
    logic [RW-1:0]                   r_cnt;
    logic                            r_bad;
    logic                            r_sel;
    logic                            r_in_tab;
    logic                            r_out_valid;
    logic [CLW-1:0]                  r_out_cluster;
    logic [OFFW-1:0]                 r_out_offset;
    logic [fat12cw_pkg::CNT_W-1:0]   r_out_count;
    logic                            r_out_last;
    fat12cw_pkg::t_status            r_out_status;

    logic                            in_fire;
    logic                            out_free;
    fat12cw_pkg::t_tbl_wr            tbl_wr;
    logic [7:0]                      b0;
    logic [7:0]                      b1;
    logic [7:0]                      b2;
    logic [CLW-1:0]                  even_idx;
    logic [CLW-1:0]                  wr_even;
    logic [CLW-1:0]                  wr_odd;
    logic [CLW-1:0]                  rd_even;
    logic [CLW-1:0]                  rd_odd;
    logic [CLW-1:0]                  nxt;
    logic                            ends;
    logic                            trunc;
    logic                            stop;
    logic                            emit;
    logic [TW-1:0]                   take;
    logic [OFFW-1:0]                 offset;
    logic                            rd_en;
    logic [CLW-1:0]                  rd_cl;
    logic                            start_bad;

    assign in_fire  = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // table load unpack
    assign b0       = i_item.table_bytes[7:0];
    assign b1       = i_item.table_bytes[15:8];
    assign b2       = i_item.table_bytes[23:16];
    assign even_idx = {i_item.pair_index, 1'b0};
    assign wr_even  = {b1[3:0], b0};
    assign wr_odd   = {b2, b1[7:4]};

    always_comb begin
        tbl_wr.we_even = in_fire && (i_item.operation == fat12cw_pkg::OP_LOAD)
                         && ({1'b0, even_idx} < (CLW + 1)'(TABLE_ENTRIES));
        tbl_wr.we_odd  = in_fire && (i_item.operation == fat12cw_pkg::OP_LOAD)
                         && ({1'b0, even_idx} + (CLW + 1)'(1) < (CLW + 1)'(TABLE_ENTRIES));
    end

    // chain step
    assign nxt   = r_in_tab ? (r_sel ? rd_odd : rd_even) : fat12cw_pkg::CL_FREE;
    assign ends  = (nxt == fat12cw_pkg::CL_FREE) || (nxt >= fat12cw_pkg::CL_EOC_LO);
    assign trunc = (r_cnt == RW'(MAX_RUN - 1));
    assign stop  = r_bad || ends || trunc;
    assign emit  = (r_state == S_EMIT) && out_free;
    assign take  = (r_rem < LENW'(SECTOR_BYTES)) ? r_rem[TW-1:0] : TW'(SECTOR_BYTES);
    assign offset = OFFW'((OFFW'(r_cl) - OFFW'(fat12cw_pkg::CL_BASE)) * OFFW'(SECTOR_BYTES));

    assign start_bad = (i_item.start_cluster == fat12cw_pkg::CL_FREE)
                       || (i_item.start_cluster inside
                           {[fat12cw_pkg::CL_EOC_LO:fat12cw_pkg::CL_BAD_HI]});

    assign rd_cl = (r_state == S_IDLE) ? i_item.start_cluster : nxt;
    assign rd_en = (in_fire && (i_item.operation == fat12cw_pkg::OP_WALK))
                   || (emit && !stop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_item.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_item.operation == fat12cw_pkg::OP_WALK)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit && stop) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end

        if (rd_en) begin
            r_sel    <= rd_cl[0];
            r_in_tab <= ({1'b0, rd_cl} < (CLW + 1)'(TABLE_ENTRIES));
        end
        if (r_state == S_IDLE) begin
            r_cl  <= i_item.start_cluster;
            r_rem <= i_item.file_length;
            r_cnt <= '0;
            r_bad <= start_bad;
        end else if (emit) begin
            r_cl  <= nxt;
            r_rem <= r_rem - LENW'(take);
            r_cnt <= r_cnt + RW'(1);
        end
        if (emit) begin
            r_out_cluster <= r_cl;
            r_out_last    <= stop;
            if (r_bad) begin
                r_out_offset <= '0;
                r_out_count  <= '0;
                r_out_status <= fat12cw_pkg::ST_BAD_START;
            end else begin
                r_out_offset <= offset;
                r_out_count  <= fat12cw_pkg::CNT_W'(take);
                r_out_status <= (!ends && trunc) ? fat12cw_pkg::ST_TRUNC
                                                 : fat12cw_pkg::ST_OK;
            end
        end
    end

    fat12cw_table #(
        .BANK_DEPTH (BANK_DEPTH),
        .BANK_AW    (BANK_AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr       (tbl_wr),
        .i_wr_addr  (i_item.pair_index[BANK_AW-1:0]),
        .i_wr_even  (wr_even),
        .i_wr_odd   (wr_odd),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_cl[EW-1:1]),
        .o_rd_even  (rd_even),
        .o_rd_odd   (rd_odd)
    );

    assign o_item.valid       = r_out_valid;
    assign o_item.cluster     = r_out_cluster;
    assign o_item.byte_offset = r_out_offset;
    assign o_item.byte_count  = r_out_count;
    assign o_item.last        = r_out_last;
    assign o_item.status      = r_out_status;

endmodule

// ----- hw/rtl/fat12cw_table.sv -----
// ----------------------------------------------------------------------------
// fat12cw_table
// FAT storage as even and odd entry banks, so one load writes a whole pair.
// Synchronous, registered read of both banks.
// ----------------------------------------------------------------------------
module fat12cw_table #(
    parameter int BANK_DEPTH = 2048,
    parameter int BANK_AW    = 11
) (
    input  logic                                i_clk,
    input  fat12cw_pkg::t_tbl_wr                i_wr,
    input  logic [BANK_AW-1:0]                  i_wr_addr,
    input  logic [fat12cw_pkg::CLUSTER_W-1:0]   i_wr_even,
    input  logic [fat12cw_pkg::CLUSTER_W-1:0]   i_wr_odd,
    input  logic                                i_rd_en,
    input  logic [BANK_AW-1:0]                  i_rd_addr,
    output logic [fat12cw_pkg::CLUSTER_W-1:0]   o_rd_even,
    output logic [fat12cw_pkg::CLUSTER_W-1:0]   o_rd_odd
);

    logic [fat12cw_pkg::CLUSTER_W-1:0] r_mem_even [BANK_DEPTH];
    logic [fat12cw_pkg::CLUSTER_W-1:0] r_mem_odd  [BANK_DEPTH];
    logic [fat12cw_pkg::CLUSTER_W-1:0] r_rd_even;
    logic [fat12cw_pkg::CLUSTER_W-1:0] r_rd_odd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_even) begin
            r_mem_even[i_wr_addr] <= i_wr_even;
        end
        if (i_rd_en) begin
            r_rd_even <= r_mem_even[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_odd) begin
            r_mem_odd[i_wr_addr] <= i_wr_odd;
        end
        if (i_rd_en) begin
            r_rd_odd <= r_mem_odd[i_rd_addr];
        end
    end

    assign o_rd_even = r_rd_even;
    assign o_rd_odd  = r_rd_odd;

endmodule

// ----- hw/rtl/fat12cw_chk.sv -----
// ----------------------------------------------------------------------------
// fat12cw_chk
// Port-level checks of the chain walker, bound to the top level.
// ----------------------------------------------------------------------------
module fat12cw_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [fat12cw_pkg::CLUSTER_W-1:0]   i_out_cluster,
    input logic [fat12cw_pkg::CNT_W-1:0]       i_out_count,
    input logic                                i_out_last,
    input logic [fat12cw_pkg::STATUS_W-1:0]    i_out_status
);

    // stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cluster)
        && $stable(i_out_last) && $stable(i_out_status))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != fat12cw_pkg::ST_OK) |-> i_out_last)
        else $error("error or truncation status without last");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == fat12cw_pkg::ST_OK)
        || (i_out_status == fat12cw_pkg::ST_BAD_START)
        || (i_out_status == fat12cw_pkg::ST_TRUNC))
        else $error("undefined status code");

    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == fat12cw_pkg::ST_BAD_START)
        |-> (i_out_count == '0))
        else $error("bad first cluster result carries bytes");

    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready in the middle of a walk");

endmodule

bind fat12_cluster_chain_walker fat12cw_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_item.valid),
    .i_out_ready    (o_item.ready),
    .i_out_cluster  (o_item.cluster),
    .i_out_count    (o_item.byte_count),
    .i_out_last     (o_item.last),
    .i_out_status   (o_item.status)
);

// ----- tb/sv/fat12_chain_checker.sv -----
// ----------------------------------------------------------------------------
// fat12_chain_checker
// Watches the walker's item channels, tracks the table image written by load
// items, predicts the result items of every accepted walk and compares each
// result field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module fat12_chain_checker #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int SECTOR_BYTES  = 512,
    parameter int MAX_RUN       = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fat12cw_in_if  i_req,
    fat12cw_out_if i_rsp,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLW  = fat12cw_pkg::CLUSTER_W;
    localparam int OFFW = fat12cw_pkg::OFF_W;
    localparam int CNTW = fat12cw_pkg::CNT_W;

    typedef struct packed {
        logic [CLW-1:0]       cluster;
        logic [OFFW-1:0]      byte_offset;
        logic [CNTW-1:0]      byte_count;
        logic                 last;
        fat12cw_pkg::t_status status;
    } t_chain_step;

    logic [CLW-1:0] fat_image [TABLE_ENTRIES];
    t_chain_step    due_steps [$];
    int             fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_total++;
        if (fail_total <= 40)
            $display("[%0t] mismatch on %s, expected %0h got %0h", $realtime, what, want, got);
    endtask

    function automatic logic [CLW-1:0] next_cluster(input logic [CLW-1:0] cl);
        if (int'(cl) >= TABLE_ENTRIES)
            return fat12cw_pkg::CL_FREE;
        return fat_image[cl];
    endfunction

    function automatic void store_pair(input logic [fat12cw_pkg::PAIR_W-1:0] pair,
                                       input logic [fat12cw_pkg::BYTES_W-1:0] raw);
        int even_idx;
        even_idx = 2 * int'(pair);
        if (even_idx < TABLE_ENTRIES)
            fat_image[even_idx] = {raw[11:8], raw[7:0]};
        if (even_idx + 1 < TABLE_ENTRIES)
            fat_image[even_idx + 1] = {raw[23:16], raw[15:12]};
    endfunction

    function automatic void predict_walk(input logic [CLW-1:0] first,
                                         input logic [fat12cw_pkg::LEN_W-1:0] length);
        logic [CLW-1:0] cl;
        logic [CLW-1:0] nxt;
        logic [31:0]    owed;
        logic [31:0]    take;
        logic [31:0]    offset;
        bit             ends;
        if (first == fat12cw_pkg::CL_FREE
            || (first >= fat12cw_pkg::CL_EOC_LO && first <= fat12cw_pkg::CL_BAD_HI)) begin
            due_steps.push_back('{first, '0, '0, 1'b1, fat12cw_pkg::ST_BAD_START});
            return;
        end
        cl   = first;
        owed = length;
        for (int n = 1; n <= MAX_RUN; n++) begin
            take   = (owed < SECTOR_BYTES) ? owed : 32'(SECTOR_BYTES);
            owed   = owed - take;
            offset = (32'(cl) - 32'(fat12cw_pkg::CL_BASE)) * 32'(SECTOR_BYTES);
            nxt    = next_cluster(cl);
            ends   = (nxt == fat12cw_pkg::CL_FREE) || (nxt >= fat12cw_pkg::CL_EOC_LO);
            if (ends) begin
                due_steps.push_back('{cl, offset[OFFW-1:0], take[CNTW-1:0], 1'b1,
                                      fat12cw_pkg::ST_OK});
                return;
            end
            if (n == MAX_RUN) begin
                due_steps.push_back('{cl, offset[OFFW-1:0], take[CNTW-1:0], 1'b1,
                                      fat12cw_pkg::ST_TRUNC});
                return;
            end
            due_steps.push_back('{cl, offset[OFFW-1:0], take[CNTW-1:0], 1'b0,
                                  fat12cw_pkg::ST_OK});
            cl = nxt;
        end
    endfunction

    always @(posedge i_clk) begin
        t_chain_step want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                if (i_req.operation == fat12cw_pkg::OP_LOAD)
                    store_pair(i_req.pair_index, i_req.table_bytes);
                else
                    predict_walk(i_req.start_cluster, i_req.file_length);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_steps.size() == 0) begin
                    report_mismatch("result with nothing due, cluster", '0, 32'(i_rsp.cluster));
                end else begin
                    want = due_steps.pop_front();
                    if (i_rsp.cluster !== want.cluster)
                        report_mismatch("cluster", 32'(want.cluster), 32'(i_rsp.cluster));
                    if (i_rsp.byte_offset !== want.byte_offset)
                        report_mismatch("byte_offset", 32'(want.byte_offset),
                                        32'(i_rsp.byte_offset));
                    if (i_rsp.byte_count !== want.byte_count)
                        report_mismatch("byte_count", 32'(want.byte_count),
                                        32'(i_rsp.byte_count));
                    if (i_rsp.last !== want.last)
                        report_mismatch("last", 32'(want.last), 32'(i_rsp.last));
                    if (i_rsp.status !== want.status)
                        report_mismatch("chain status", 32'(want.status), 32'(i_rsp.status));
                end
            end
        end
        o_pending <= due_steps.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives load and walk items into the FAT12 cluster chain walker: a directed
// pass over the extremes and corner cases, then random chains built entry by
// entry and walked with random file sizes, mixed with stray loads and walks.
// A table shadow keeps every walk on entries that were loaded. Both sides
// idle at random; the checker beside the block gives the failure count.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SECTOR_BYTES  = 512;
    localparam int MAX_RUN       = 64;
    localparam int ITEM_TARGET   = 480;
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int CLW           = fat12cw_pkg::CLUSTER_W;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent = 0;
    int   cycles     = 0;
    bit   src_calm   = 0;
    bit   sink_calm  = 0;
    int   sink_hold  = 0;

    logic [CLW-1:0] shadow [TABLE_ENTRIES];
    bit             loaded [TABLE_ENTRIES];

    fat12cw_in_if  req ();
    fat12cw_out_if rsp ();

    fat12_cluster_chain_walker #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .MAX_RUN      (MAX_RUN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (req),
        .o_item (rsp)
    );

    fat12_chain_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .MAX_RUN      (MAX_RUN)
    ) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_rsp       (rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold   <= sink_hold - 1;
            rsp.ready   <= 1'b0;
        end else if (!sink_calm && $urandom_range(0, 99) < 30) begin
            sink_hold   <= idle_len(1'b0);
            rsp.ready   <= 1'b0;
        end else begin
            rsp.ready   <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0)
            sink_calm <= !sink_calm;
    end

    task automatic drive_item(input logic op, input logic [fat12cw_pkg::PAIR_W-1:0] pair,
                              input logic [fat12cw_pkg::BYTES_W-1:0] raw,
                              input logic [CLW-1:0] start,
                              input logic [fat12cw_pkg::LEN_W-1:0] length);
        int gap;
        req.valid         <= 1'b1;
        req.operation     <= op;
        req.pair_index    <= pair;
        req.table_bytes   <= raw;
        req.start_cluster <= start;
        req.file_length   <= length;
        @(posedge i_clk);
        while (!req.ready)
            @(posedge i_clk);
        items_sent++;
        gap = idle_len(src_calm);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic load_pair(input logic [fat12cw_pkg::PAIR_W-1:0] pair,
                             input logic [CLW-1:0] even, input logic [CLW-1:0] odd);
        shadow[{pair, 1'b0}] = even;
        shadow[{pair, 1'b1}] = odd;
        loaded[{pair, 1'b0}] = 1'b1;
        loaded[{pair, 1'b1}] = 1'b1;
        drive_item(fat12cw_pkg::OP_LOAD, pair, {odd, even}, 12'($urandom), $urandom);
    endtask

    task automatic send_walk(input logic [CLW-1:0] start,
                             input logic [fat12cw_pkg::LEN_W-1:0] length);
        drive_item(fat12cw_pkg::OP_WALK, 11'($urandom), 24'($urandom), start, length);
    endtask

    // Writing one entry rewrites its partner too: keep the partner if known.
    task automatic set_entry(input logic [CLW-1:0] idx, input logic [CLW-1:0] val);
        logic [CLW-1:0] mate;
        mate = loaded[idx ^ 12'd1] ? shadow[idx ^ 12'd1] : 12'($urandom);
        if (idx[0])
            load_pair(idx[11:1], mate, val);
        else
            load_pair(idx[11:1], val, mate);
    endtask

    function automatic bit chain_safe(input logic [CLW-1:0] start);
        logic [CLW-1:0] cl;
        if (start == fat12cw_pkg::CL_FREE
            || (start >= fat12cw_pkg::CL_EOC_LO && start <= fat12cw_pkg::CL_BAD_HI))
            return 1'b1;
        cl = start;
        for (int n = 0; n < MAX_RUN; n++) begin
            if (!loaded[cl])
                return 1'b0;
            if (shadow[cl] == fat12cw_pkg::CL_FREE || shadow[cl] >= fat12cw_pkg::CL_EOC_LO)
                return 1'b1;
            cl = shadow[cl];
        end
        return 1'b1;
    endfunction

    function automatic logic [CLW-1:0] bad_start();
        if ($urandom_range(0, 1) == 0)
            return fat12cw_pkg::CL_FREE;
        return fat12cw_pkg::CL_EOC_LO + 12'($urandom_range(0, 7));
    endfunction

    function automatic logic [CLW-1:0] end_marker();
        if ($urandom_range(0, 3) == 0)
            return fat12cw_pkg::CL_FREE;
        return fat12cw_pkg::CL_EOC_LO + 12'($urandom_range(0, 15));
    endfunction

    function automatic logic [fat12cw_pkg::LEN_W-1:0] pick_length(input int clusters);
        case ($urandom_range(0, 3))
            0: begin
                return $urandom;
            end
            1: begin
                return $urandom_range(0, clusters * SECTOR_BYTES + 600);
            end
            2: begin
                return clusters * SECTOR_BYTES + $urandom_range(0, 2) - 1;
            end
            default: begin
                return $urandom_range(0, 1023);
            end
        endcase
    endfunction

    task automatic build_chain(input int len, input bit loop_back,
                               output logic [CLW-1:0] head);
        logic [CLW-1:0] nodes [$];
        logic [CLW-1:0] c;
        bit             taken [TABLE_ENTRIES];
        while (nodes.size() < len) begin
            c = ($urandom_range(0, 19) == 0) ? 12'd1 : 12'($urandom_range(2, 12'hFEF));
            if (!taken[c]) begin
                taken[c] = 1'b1;
                nodes.push_back(c);
            end
        end
        for (int k = 0; k < len; k++) begin
            if (k + 1 < len)
                set_entry(nodes[k], nodes[k + 1]);
            else if (loop_back)
                set_entry(nodes[k], nodes[$urandom_range(0, k)]);
            else
                set_entry(nodes[k], end_marker());
        end
        head = nodes[0];
    endtask

    initial begin
        logic [CLW-1:0] head;
        logic [CLW-1:0] start;
        int             pick;
        int             len;
        bit             found;

        i_rst_n           = 1'b0;
        req.valid         = 1'b0;
        req.operation     = fat12cw_pkg::OP_LOAD;
        req.pair_index    = '0;
        req.table_bytes   = '0;
        req.start_cluster = '0;
        req.file_length   = '0;
        rsp.ready         = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_pair(11'd0, 12'h123, 12'hFFF);
        load_pair(11'd2047, 12'hFFF, 12'hFFF);
        load_pair(11'd5, 12'h000, 12'h000);
        load_pair(11'd1, 12'd3, 12'd2);
        load_pair(11'd3, 12'd7, fat12cw_pkg::CL_FREE);
        load_pair(11'd4, fat12cw_pkg::CL_EOC_LO, fat12cw_pkg::CL_BAD_HI);
        load_pair(11'd2044, 12'hFF8, 12'd1);
        send_walk(fat12cw_pkg::CL_FREE, 32'd100);
        send_walk(fat12cw_pkg::CL_EOC_LO, 32'hFFFF_FFFF);
        send_walk(fat12cw_pkg::CL_BAD_HI, 32'd0);
        send_walk(12'hFF8, 32'hFFFF_FFFF);
        send_walk(12'd4095, 32'd512);
        send_walk(12'd4094, 32'd513);
        send_walk(12'd1, 32'd1);
        send_walk(12'd2, 32'hFFFF_FFFF);
        send_walk(12'd2, 32'd0);
        send_walk(12'd6, 32'd700);
        send_walk(12'd8, 32'd513);
        send_walk(12'd9, 32'd511);
        send_walk(12'd4089, 32'd1024);
        send_walk(12'd10, 32'd5);
        send_walk(12'hFF5, 32'd0);
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = $urandom_range(0, 99);
                if (len < 80)
                    len = $urandom_range(1, 8);
                else if (len < 95)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(60, 70);
                build_chain(len, $urandom_range(0, 9) == 0, head);
                send_walk(head, pick_length(len));
            end else if (pick < 70) begin
                load_pair(11'($urandom), 12'($urandom), 12'($urandom));
            end else if (pick < 85) begin
                start = 12'($urandom);
                if (!chain_safe(start))
                    start = bad_start();
                send_walk(start, pick_length(4));
            end else begin
                found = 1'b0;
                for (int t = 0; t < 30 && !found; t++) begin
                    start = 12'($urandom);
                    found = loaded[start] && chain_safe(start);
                end
                if (found)
                    send_walk(start, pick_length(8));
            end
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            if ($urandom_range(0, 19) == 0)
                src_calm = !src_calm;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
    end

endmodule
